/* design/mvne_pkg.sv */
package mvne_pkg;

  localparam int IdxW     = 12;
  localparam int Depth    = 4096;
  localparam int CoordW   = 20;
  localparam int EdgeW    = CoordW + 1;
  localparam int CrossW   = 2 * EdgeW + 1;
  localparam int AccW     = 24;
  localparam int NormW    = 16;
  localparam int FracBits = 14;
  localparam int SqW      = 62;
  localparam int RootW    = 31;
  localparam int NumW     = 46;
  localparam int QuoW     = 16;
  localparam int MagW     = 30;

  localparam logic [NormW-1:0] NormOne = NormW'(1) << FracBits;

  // command codes on the input word
  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_TRI   = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;
  localparam logic [1:0] CMD_CLEAR = 2'd3;

  typedef enum logic [1:0] {SEL_A, SEL_B, SEL_C, SEL_VI} sel_e;

  typedef enum logic [4:0] {
    OP_NONE, OP_LATCH, OP_WRPOS, OP_CLRACC, OP_SWEEP, OP_LDACC,
    OP_PA, OP_EB, OP_EC, OP_MUL, OP_MAG, OP_SHR, OP_SHL, OP_SQ,
    OP_SQINIT, OP_SQRT, OP_DINIT, OP_DIV, OP_DFIN, OP_AWR, OP_OUT, OP_OUTZ
  } dp_op_e;

  typedef struct packed {
    dp_op_e          op;
    sel_e            sel;
    logic [2:0]      step;
    logic [IdxW-1:0] addr;
  } dp_cmd_t;

  typedef struct packed {
    logic top_zero;
    logic top_hi;
    logic top_lo;
    logic out_busy;
  } dp_sts_t;

endpackage

/* design/mesh_vertex_normal_engine_core.sv */
// Channel | Handshake              | Payload
// input   | in_valid_i / in_stall_o | command_i, vertex_index_i, pos_x/y/z_i, corner_a/b/c_i
// output  | out_valid_o / out_stall_i | normal_x/y/z_o, zero_normal_o
//
// One word at a time. A triangle takes three position reads, six products on
// the shared multiplier, the normalising shifts, 31 root steps, three 16-step
// divides and three accumulator read-modify-writes; a zero-length product
// ends before the root. A read runs the normalise, root and divide steps on
// the stored accumulator. After reset a pass over every accumulator entry
// zeroes them; input stalls meanwhile. The result sits in an output register,
// so a stalled output only holds up a later read at its final delivery step.
module mesh_vertex_normal_engine_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [1:0]                           command_i,
  input  logic [mvne_pkg::IdxW-1:0]            vertex_index_i,
  input  logic signed [mvne_pkg::CoordW-1:0]   pos_x_i,
  input  logic signed [mvne_pkg::CoordW-1:0]   pos_y_i,
  input  logic signed [mvne_pkg::CoordW-1:0]   pos_z_i,
  input  logic [mvne_pkg::IdxW-1:0]            corner_a_i,
  input  logic [mvne_pkg::IdxW-1:0]            corner_b_i,
  input  logic [mvne_pkg::IdxW-1:0]            corner_c_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [mvne_pkg::NormW-1:0]    normal_x_o,
  output logic signed [mvne_pkg::NormW-1:0]    normal_y_o,
  output logic signed [mvne_pkg::NormW-1:0]    normal_z_o,
  output logic                                 zero_normal_o
);
  import mvne_pkg::*;

  // controller sequences, datapath holds both stores and the arithmetic
  dp_cmd_t cmd;
  dp_sts_t sts;

  mvne_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .command_i  (command_i),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  mvne_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .vertex_index_i (vertex_index_i),
    .pos_x_i        (pos_x_i),
    .pos_y_i        (pos_y_i),
    .pos_z_i        (pos_z_i),
    .corner_a_i     (corner_a_i),
    .corner_b_i     (corner_b_i),
    .corner_c_i     (corner_c_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .normal_x_o     (normal_x_o),
    .normal_y_o     (normal_y_o),
    .normal_z_o     (normal_z_o),
    .zero_normal_o  (zero_normal_o)
  );

endmodule

/* design/mvne_ctrl.sv */
module mvne_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [1:0]        command_i,
  output logic              in_stall_o,
  output mvne_pkg::dp_cmd_t cmd_o,
  input  mvne_pkg::dp_sts_t sts_i
);
  import mvne_pkg::*;

  typedef enum logic [4:0] {
    S_SWEEP, S_IDLE, S_WRPOS, S_CLRA, S_RDA, S_LDACC, S_PA, S_PB, S_PC, S_PE,
    S_MUL, S_MAG, S_NORM, S_SQ, S_SQI, S_SQRT, S_DI, S_DIV, S_DF, S_ARD,
    S_AWR, S_OUT, S_OUTZ
  } state_e;

  state_e          state_q;
  logic [IdxW-1:0] cnt_q;
  logic [1:0]      comp_q;
  logic            rd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_SWEEP;
      cnt_q   <= '0;
      comp_q  <= '0;
      rd_q    <= 1'b0;
    end else begin
      unique case (state_q)
        S_SWEEP: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == '1) state_q <= S_IDLE;
        end
        S_IDLE: begin
          cnt_q  <= '0;
          comp_q <= '0;
          if (in_valid_i) begin
            rd_q <= (command_i == CMD_READ);
            unique case (command_i)
              CMD_WRITE: state_q <= S_WRPOS;
              CMD_TRI:   state_q <= S_PA;
              CMD_READ:  state_q <= S_RDA;
              default:   state_q <= S_CLRA;
            endcase
          end
        end
        S_WRPOS, S_CLRA: state_q <= S_IDLE;
        S_RDA:   state_q <= S_LDACC;
        S_LDACC: state_q <= S_MAG;
        S_PA:    state_q <= S_PB;
        S_PB:    state_q <= S_PC;
        S_PC:    state_q <= S_PE;
        S_PE:    state_q <= S_MUL;
        S_MUL: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == IdxW'(6)) state_q <= S_MAG;
        end
        S_MAG: state_q <= S_NORM;
        S_NORM: begin
          cnt_q <= '0;
          if (sts_i.top_zero) state_q <= rd_q ? S_OUTZ : S_IDLE;
          else if (!sts_i.top_hi && !sts_i.top_lo) state_q <= S_SQ;
        end
        S_SQ: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == IdxW'(3)) state_q <= S_SQI;
        end
        S_SQI: begin
          cnt_q   <= '0;
          state_q <= S_SQRT;
        end
        S_SQRT: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == IdxW'(RootW - 1)) begin
            comp_q  <= '0;
            state_q <= S_DI;
          end
        end
        S_DI: begin
          cnt_q   <= '0;
          state_q <= S_DIV;
        end
        S_DIV: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == IdxW'(QuoW - 1)) state_q <= S_DF;
        end
        S_DF: begin
          if (comp_q == 2'd2) begin
            comp_q  <= '0;
            state_q <= rd_q ? S_OUT : S_ARD;
          end else begin
            comp_q  <= comp_q + 1'b1;
            state_q <= S_DI;
          end
        end
        S_ARD: state_q <= S_AWR;
        S_AWR: begin
          if (comp_q == 2'd2) state_q <= S_IDLE;
          else begin
            comp_q  <= comp_q + 1'b1;
            state_q <= S_ARD;
          end
        end
        S_OUT, S_OUTZ: if (!sts_i.out_busy) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    cmd_o      = '0;
    cmd_o.op   = OP_NONE;
    cmd_o.sel  = SEL_VI;
    cmd_o.step = cnt_q[2:0];
    cmd_o.addr = cnt_q;
    unique case (state_q)
      S_SWEEP: cmd_o.op = OP_SWEEP;
      S_IDLE:  cmd_o.op = in_valid_i ? OP_LATCH : OP_NONE;
      S_WRPOS: cmd_o.op = OP_WRPOS;
      S_CLRA:  cmd_o.op = OP_CLRACC;
      S_RDA:   cmd_o.sel = SEL_VI;
      S_LDACC: cmd_o.op = OP_LDACC;
      S_PA:    cmd_o.sel = SEL_A;
      S_PB: begin
        cmd_o.sel = SEL_B;
        cmd_o.op  = OP_PA;
      end
      S_PC: begin
        cmd_o.sel = SEL_C;
        cmd_o.op  = OP_EB;
      end
      S_PE:    cmd_o.op = OP_EC;
      S_MUL:   cmd_o.op = OP_MUL;
      S_MAG:   cmd_o.op = OP_MAG;
      S_NORM: begin
        priority if (sts_i.top_zero) cmd_o.op = OP_NONE;
        else if (sts_i.top_hi)       cmd_o.op = OP_SHR;
        else if (sts_i.top_lo)       cmd_o.op = OP_SHL;
        else                         cmd_o.op = OP_NONE;
      end
      S_SQ:    cmd_o.op = OP_SQ;
      S_SQI:   cmd_o.op = OP_SQINIT;
      S_SQRT:  cmd_o.op = OP_SQRT;
      S_DI: begin
        cmd_o.op   = OP_DINIT;
        cmd_o.step = {1'b0, comp_q};
      end
      S_DIV:   cmd_o.op = OP_DIV;
      S_DF: begin
        cmd_o.op   = OP_DFIN;
        cmd_o.step = {1'b0, comp_q};
      end
      S_ARD:   cmd_o.sel = sel_e'(comp_q);
      S_AWR: begin
        cmd_o.op  = OP_AWR;
        cmd_o.sel = sel_e'(comp_q);
      end
      S_OUT:   cmd_o.op = sts_i.out_busy ? OP_NONE : OP_OUT;
      S_OUTZ:  cmd_o.op = sts_i.out_busy ? OP_NONE : OP_OUTZ;
      default: cmd_o.op = OP_NONE;
    endcase
  end

endmodule

/* design/mvne_dp.sv */
module mvne_dp (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  mvne_pkg::dp_cmd_t                    cmd_i,
  output mvne_pkg::dp_sts_t                    sts_o,
  input  logic [mvne_pkg::IdxW-1:0]            vertex_index_i,
  input  logic signed [mvne_pkg::CoordW-1:0]   pos_x_i,
  input  logic signed [mvne_pkg::CoordW-1:0]   pos_y_i,
  input  logic signed [mvne_pkg::CoordW-1:0]   pos_z_i,
  input  logic [mvne_pkg::IdxW-1:0]            corner_a_i,
  input  logic [mvne_pkg::IdxW-1:0]            corner_b_i,
  input  logic [mvne_pkg::IdxW-1:0]            corner_c_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [mvne_pkg::NormW-1:0]    normal_x_o,
  output logic signed [mvne_pkg::NormW-1:0]    normal_y_o,
  output logic signed [mvne_pkg::NormW-1:0]    normal_z_o,
  output logic                                 zero_normal_o
);
  import mvne_pkg::*;

  function automatic logic signed [EdgeW-1:0] edge_of(logic [CoordW-1:0] p,
                                                      logic [CoordW-1:0] q);
    return EdgeW'($signed(p)) - EdgeW'($signed(q));
  endfunction

  function automatic logic [AccW-1:0] sat_add(logic [AccW-1:0] acc,
                                              logic signed [NormW-1:0] n);
    logic signed [AccW:0] t;
    t = (AccW+1)'($signed(acc)) + (AccW+1)'(n);
    if (t[AccW] != t[AccW-1]) return t[AccW] ? {1'b1, {(AccW-1){1'b0}}}
                                             : {1'b0, {(AccW-1){1'b1}}};
    return t[AccW-1:0];
  endfunction

  logic [3*CoordW-1:0] pos_mem [Depth];
  logic [3*AccW-1:0]   acc_mem [Depth];
  logic [3*CoordW-1:0] pos_rd_q;
  logic [3*AccW-1:0]   acc_rd_q;

  logic [IdxW-1:0]     vi_q, ca_q, cb_q, cc_q;
  logic [3*CoordW-1:0] pos_in_q, pa_q;
  logic [IdxW-1:0]     mem_addr;

  logic signed [EdgeW-1:0]  e_q [6];
  logic signed [CrossW-1:0] c_q [3];
  logic [CrossW-1:0]        m_q [3];
  logic signed [63:0]       prod_q;
  logic signed [31:0]       mul_a, mul_b;
  logic signed [63:0]       mul_p;
  logic [SqW-1:0]           s_q, rem_q, root_q, bit_q, sq_t;
  logic [NumW-1:0]          num_q, dv_q;
  logic [QuoW-1:0]          quo_q, q_cap;
  logic [MagW-1:0]          m_sel;
  logic                     c_neg;
  logic signed [NormW-1:0]  n_q [3];

  logic                     out_valid_q, zero_q, out_load;
  logic signed [NormW-1:0]  nx_q, ny_q, nz_q;

  always_comb begin
    unique case (cmd_i.sel)
      SEL_A:   mem_addr = ca_q;
      SEL_B:   mem_addr = cb_q;
      SEL_C:   mem_addr = cc_q;
      default: mem_addr = vi_q;
    endcase
  end

  // memories: one write and one registered read per cycle each
  always_ff @(posedge clk_i) begin
    pos_rd_q <= pos_mem[mem_addr];
    if (cmd_i.op == OP_WRPOS) pos_mem[vi_q] <= pos_in_q;
  end

  always_ff @(posedge clk_i) begin
    acc_rd_q <= acc_mem[mem_addr];
    if (cmd_i.op == OP_SWEEP)  acc_mem[cmd_i.addr] <= '0;
    if (cmd_i.op == OP_CLRACC) acc_mem[vi_q] <= '0;
    if (cmd_i.op == OP_AWR)
      acc_mem[mem_addr] <= {sat_add(acc_rd_q[3*AccW-1:2*AccW], n_q[0]),
                            sat_add(acc_rd_q[2*AccW-1:AccW], n_q[1]),
                            sat_add(acc_rd_q[AccW-1:0], n_q[2])};
  end

  // shared multiplier: cross-product terms, then squares
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (cmd_i.op == OP_SQ) begin
      unique case (cmd_i.step)
        3'd0: mul_a = $signed({2'b00, m_q[0][MagW-1:0]});
        3'd1: mul_a = $signed({2'b00, m_q[1][MagW-1:0]});
        3'd2: mul_a = $signed({2'b00, m_q[2][MagW-1:0]});
        default: mul_a = '0;
      endcase
      mul_b = mul_a;
    end else begin
      unique case (cmd_i.step)
        3'd0: begin mul_a = 32'(e_q[1]); mul_b = 32'(e_q[5]); end
        3'd1: begin mul_a = 32'(e_q[2]); mul_b = 32'(e_q[4]); end
        3'd2: begin mul_a = 32'(e_q[2]); mul_b = 32'(e_q[3]); end
        3'd3: begin mul_a = 32'(e_q[0]); mul_b = 32'(e_q[5]); end
        3'd4: begin mul_a = 32'(e_q[0]); mul_b = 32'(e_q[4]); end
        3'd5: begin mul_a = 32'(e_q[1]); mul_b = 32'(e_q[3]); end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end
  end
  assign mul_p = mul_a * mul_b;

  always_comb begin
    unique case (cmd_i.step)
      3'd0:    begin m_sel = m_q[0][MagW-1:0]; c_neg = c_q[0][CrossW-1]; end
      3'd1:    begin m_sel = m_q[1][MagW-1:0]; c_neg = c_q[1][CrossW-1]; end
      3'd2:    begin m_sel = m_q[2][MagW-1:0]; c_neg = c_q[2][CrossW-1]; end
      default: begin m_sel = '0; c_neg = 1'b0; end
    endcase
  end

  assign sq_t  = root_q + bit_q;
  assign q_cap = (quo_q > NormOne) ? NormOne : quo_q;

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_LATCH: begin
        vi_q     <= vertex_index_i;
        ca_q     <= corner_a_i;
        cb_q     <= corner_b_i;
        cc_q     <= corner_c_i;
        pos_in_q <= {pos_x_i, pos_y_i, pos_z_i};
      end
      OP_LDACC: begin
        c_q[0] <= CrossW'($signed(acc_rd_q[3*AccW-1:2*AccW]));
        c_q[1] <= CrossW'($signed(acc_rd_q[2*AccW-1:AccW]));
        c_q[2] <= CrossW'($signed(acc_rd_q[AccW-1:0]));
      end
      OP_PA: pa_q <= pos_rd_q;
      OP_EB: begin
        e_q[0] <= edge_of(pos_rd_q[3*CoordW-1:2*CoordW], pa_q[3*CoordW-1:2*CoordW]);
        e_q[1] <= edge_of(pos_rd_q[2*CoordW-1:CoordW], pa_q[2*CoordW-1:CoordW]);
        e_q[2] <= edge_of(pos_rd_q[CoordW-1:0], pa_q[CoordW-1:0]);
      end
      OP_EC: begin
        e_q[3] <= edge_of(pos_rd_q[3*CoordW-1:2*CoordW], pa_q[3*CoordW-1:2*CoordW]);
        e_q[4] <= edge_of(pos_rd_q[2*CoordW-1:CoordW], pa_q[2*CoordW-1:CoordW]);
        e_q[5] <= edge_of(pos_rd_q[CoordW-1:0], pa_q[CoordW-1:0]);
      end
      OP_MUL: begin
        prod_q <= mul_p;
        unique case (cmd_i.step)
          3'd1: c_q[0] <= prod_q[CrossW-1:0];
          3'd2: c_q[0] <= c_q[0] - prod_q[CrossW-1:0];
          3'd3: c_q[1] <= prod_q[CrossW-1:0];
          3'd4: c_q[1] <= c_q[1] - prod_q[CrossW-1:0];
          3'd5: c_q[2] <= prod_q[CrossW-1:0];
          3'd6: c_q[2] <= c_q[2] - prod_q[CrossW-1:0];
          default: ;
        endcase
      end
      OP_MAG: begin
        for (int i = 0; i < 3; i++)
          m_q[i] <= c_q[i][CrossW-1] ? $unsigned(-c_q[i]) : $unsigned(c_q[i]);
      end
      OP_SHR: for (int i = 0; i < 3; i++) m_q[i] <= m_q[i] >> 1;
      OP_SHL: for (int i = 0; i < 3; i++) m_q[i] <= m_q[i] << 1;
      OP_SQ: begin
        prod_q <= mul_p;
        if (cmd_i.step == 3'd1) s_q <= prod_q[SqW-1:0];
        else if (cmd_i.step != 3'd0) s_q <= s_q + prod_q[SqW-1:0];
      end
      OP_SQINIT: begin
        rem_q  <= s_q;
        root_q <= '0;
        bit_q  <= SqW'(1) << (2 * (RootW - 1));
      end
      OP_SQRT: begin
        if (rem_q >= sq_t) begin
          rem_q  <= rem_q - sq_t;
          root_q <= (root_q >> 1) + bit_q;
        end else begin
          root_q <= root_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      OP_DINIT: begin
        // rounded quotient: (m * 2^frac + floor(r/2)) / r
        num_q <= {{(NumW-MagW-FracBits){1'b0}}, m_sel, {FracBits{1'b0}}}
                 + NumW'(root_q[RootW-1:1]);
        dv_q  <= {root_q[RootW-1:0], {(QuoW-1){1'b0}}};
        quo_q <= '0;
      end
      OP_DIV: begin
        if (num_q >= dv_q) num_q <= num_q - dv_q;
        quo_q <= {quo_q[QuoW-2:0], (num_q >= dv_q)};
        dv_q  <= dv_q >> 1;
      end
      OP_DFIN: begin
        unique case (cmd_i.step)
          3'd0: n_q[0] <= c_neg ? -$signed(q_cap) : $signed(q_cap);
          3'd1: n_q[1] <= c_neg ? -$signed(q_cap) : $signed(q_cap);
          3'd2: n_q[2] <= c_neg ? -$signed(q_cap) : $signed(q_cap);
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  assign sts_o.top_zero = ~|{m_q[0], m_q[1], m_q[2]};
  assign sts_o.top_hi   = |{m_q[0][CrossW-1:MagW], m_q[1][CrossW-1:MagW],
                            m_q[2][CrossW-1:MagW]};
  assign sts_o.top_lo   = ~|{m_q[0][CrossW-1:MagW-1], m_q[1][CrossW-1:MagW-1],
                             m_q[2][CrossW-1:MagW-1]};
  assign sts_o.out_busy = out_valid_q & out_stall_i;

  // output word register
  assign out_load = (cmd_i.op == OP_OUT) || (cmd_i.op == OP_OUTZ);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (out_load) out_valid_q <= 1'b1;
    else if (!out_stall_i) out_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_OUT) begin
      nx_q   <= n_q[0];
      ny_q   <= n_q[1];
      nz_q   <= n_q[2];
      zero_q <= 1'b0;
    end else if (cmd_i.op == OP_OUTZ) begin
      nx_q   <= '0;
      ny_q   <= '0;
      nz_q   <= '0;
      zero_q <= 1'b1;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign normal_x_o    = nx_q;
  assign normal_y_o    = ny_q;
  assign normal_z_o    = nz_q;
  assign zero_normal_o = zero_q;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> !(out_valid_q && out_stall_i))
    else $error("output word overwritten while stalled");

  a_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && zero_q) |-> (nx_q == 0 && ny_q == 0 && nz_q == 0))
    else $error("zero flag with non-zero normal");

  a_sum_normalised: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_SQINIT) |-> (s_q[SqW-1:2*(MagW-1)] != '0))
    else $error("square sum below normalised range");

  a_unit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !zero_q) |->
      (nx_q >= -16384 && nx_q <= 16384 && ny_q >= -16384 && ny_q <= 16384 &&
       nz_q >= -16384 && nz_q <= 16384))
    else $error("normal component out of unit range");

endmodule

/* bench/tb.sv */
module tb;
  import mvne_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [1:0] command_i = CMD_WRITE;
  logic [IdxW-1:0] vertex_index_i = '0;
  logic signed [CoordW-1:0] pos_x_i = '0, pos_y_i = '0, pos_z_i = '0;
  logic [IdxW-1:0] corner_a_i = '0, corner_b_i = '0, corner_c_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [NormW-1:0] normal_x_o, normal_y_o, normal_z_o;
  logic zero_normal_o;

  typedef struct packed {
    logic signed [NormW-1:0] nx, ny, nz;
    logic zero;
  } normal_word_t;

  // model state: positions, written flags, accumulators
  longint pos_mem [Depth][3];
  bit written [Depth];
  int acc_mem [Depth][3];
  normal_word_t pending_normals [$];
  int errors = 0;
  int burst_left = 0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  mesh_vertex_normal_engine_core DUT (.*);

  function automatic longint unsigned isqrt(longint unsigned s);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > s) b >>= 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // scale to Q1.14 unit vector; returns 0 for zero input
  function automatic bit to_unit(input longint c [3], output int n [3]);
    longint unsigned m [3];
    longint unsigned top, s, r, q;
    top = 0;
    s = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = c[i] < 0 ? -c[i] : c[i];
      if (m[i] > top) top = m[i];
      n[i] = 0;
    end
    if (top == 0) return 0;
    while (top >= (64'd1 << 30)) begin
      for (int i = 0; i < 3; i++) m[i] >>= 1;
      top >>= 1;
    end
    while (top < (64'd1 << 29)) begin
      for (int i = 0; i < 3; i++) m[i] <<= 1;
      top <<= 1;
    end
    for (int i = 0; i < 3; i++) s += m[i] * m[i];
    r = isqrt(s);
    for (int i = 0; i < 3; i++) begin
      q = ((m[i] << FracBits) + r / 2) / r;
      if (q > (64'd1 << FracBits)) q = 64'd1 << FracBits;
      n[i] = c[i] < 0 ? -int'(q) : int'(q);
    end
    return 1;
  endfunction

  function automatic int sat_acc(int a, int v);
    longint t;
    t = longint'(a) + v;
    if (t > 8388607) t = 8388607;
    if (t < -8388608) t = -8388608;
    return int'(t);
  endfunction

  function automatic void predict_word(logic [1:0] cmd, int vi, longint px, longint py,
                                       longint pz, int ca, int cb, int cc);
    longint unsigned em [6];
    longint e [6];
    longint cr [3];
    longint unsigned top;
    int n [3];
    int idx [3];
    normal_word_t w;
    bit ok;
    case (cmd)
      CMD_WRITE: begin
        pos_mem[vi][0] = px;
        pos_mem[vi][1] = py;
        pos_mem[vi][2] = pz;
        written[vi] = 1;
      end
      CMD_CLEAR: begin
        for (int i = 0; i < 3; i++) acc_mem[vi][i] = 0;
      end
      CMD_TRI: begin
        top = 0;
        for (int i = 0; i < 3; i++) begin
          e[i] = pos_mem[cb][i] - pos_mem[ca][i];
          e[i+3] = pos_mem[cc][i] - pos_mem[ca][i];
        end
        for (int i = 0; i < 6; i++) begin
          em[i] = e[i] < 0 ? -e[i] : e[i];
          if (em[i] > top) top = em[i];
        end
        while (top >= (64'd1 << 30)) begin
          for (int i = 0; i < 6; i++) em[i] >>= 1;
          top >>= 1;
        end
        for (int i = 0; i < 6; i++) e[i] = e[i] < 0 ? -longint'(em[i]) : longint'(em[i]);
        cr[0] = e[1] * e[5] - e[2] * e[4];
        cr[1] = e[2] * e[3] - e[0] * e[5];
        cr[2] = e[0] * e[4] - e[1] * e[3];
        ok = to_unit(cr, n);
        idx[0] = ca;
        idx[1] = cb;
        idx[2] = cc;
        for (int k = 0; k < 3; k++)
          for (int i = 0; i < 3; i++) acc_mem[idx[k]][i] = sat_acc(acc_mem[idx[k]][i], n[i]);
      end
      default: begin
        for (int i = 0; i < 3; i++) cr[i] = acc_mem[vi][i];
        ok = to_unit(cr, n);
        w.nx = NormW'(n[0]);
        w.ny = NormW'(n[1]);
        w.nz = NormW'(n[2]);
        w.zero = !ok;
        pending_normals.push_back(w);
      end
    endcase
  endfunction

  // one word to the block; sender idles in bursts
  task automatic send_word(logic [1:0] cmd, int vi, int px = 0, int py = 0, int pz = 0,
                           int ca = 0, int cb = 0, int cc = 0);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    command_i <= cmd;
    vertex_index_i <= IdxW'(vi);
    pos_x_i <= CoordW'(px);
    pos_y_i <= CoordW'(py);
    pos_z_i <= CoordW'(pz);
    corner_a_i <= IdxW'(ca);
    corner_b_i <= IdxW'(cb);
    corner_c_i <= IdxW'(cc);
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_word(cmd, vi, longint'(signed'(CoordW'(px))), longint'(signed'(CoordW'(py))),
                 longint'(signed'(CoordW'(pz))), ca, cb, cc);
  endtask

  function automatic int rnd_coord();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 1) ? 524287 : -524288;
      1: return int'($urandom_range(0, 200)) - 100;
      default: return int'($urandom_range(0, 1048575)) - 524288;
    endcase
  endfunction

  function automatic int rnd_written();
    int v;
    do v = $urandom_range(0, Depth - 1); while (!written[v]);
    return v;
  endfunction

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_normals.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  // directed: extremes, degenerate triangle, clear, zero reads
  task automatic test_directed();
    send_word(CMD_READ, 0);
    send_word(CMD_WRITE, 0, 0, 0, 0);
    send_word(CMD_WRITE, 1, 524287, 0, 0);
    send_word(CMD_WRITE, 2, 0, 524287, 0);
    send_word(CMD_WRITE, 3, -524288, -524288, -524288);
    send_word(CMD_WRITE, 4095, 524287, 524287, 524287);
    send_word(CMD_TRI, 0, 0, 0, 0, 0, 1, 2);
    send_word(CMD_READ, 0);
    send_word(CMD_TRI, 0, 0, 0, 0, 3, 4095, 1);
    send_word(CMD_TRI, 0, 0, 0, 0, 0, 0, 1);
    send_word(CMD_TRI, 0, 0, 0, 0, 3, 0, 4095);
    send_word(CMD_READ, 4095);
    send_word(CMD_READ, 3);
    send_word(CMD_CLEAR, 0);
    send_word(CMD_READ, 0);
    send_word(CMD_READ, 1);
    send_word(CMD_CLEAR, 4095);
    send_word(CMD_READ, 4095);
  endtask

  // many identical triangles drive the z accumulators into saturation
  task automatic test_saturation();
    for (int i = 0; i < 520; i++) send_word(CMD_TRI, 0, 0, 0, 0, 0, 1, 2);
    send_word(CMD_READ, 0);
    send_word(CMD_READ, 1);
    send_word(CMD_READ, 2);
    drain_results();
  endtask

  task automatic test_random(int n);
    int roll;
    for (int i = 0; i < n; i++) begin
      roll = $urandom_range(0, 9);
      if (roll < 3) send_word(CMD_WRITE, $urandom_range(0, 1) ? $urandom_range(0, 15) :
                              $urandom_range(0, Depth - 1), rnd_coord(), rnd_coord(), rnd_coord());
      else if (roll < 6) send_word(CMD_TRI, 0, 0, 0, 0, rnd_written(), rnd_written(),
                                   rnd_written());
      else if (roll < 9) send_word(CMD_READ, $urandom_range(0, 3) == 0 ?
                                   $urandom_range(0, Depth - 1) : rnd_written());
      else send_word(CMD_CLEAR, rnd_written());
      if (i == n / 2) drain_results();
    end
  endtask

  // receiver stall pattern, with quiet stretches
  initial begin
    int mode;
    forever begin
      mode = $urandom_range(0, 2);
      repeat ($urandom_range(20, 300)) begin
        @(posedge clk_i);
        out_stall_i <= (mode == 0) ? 1'b0 : (mode == 1 ? ($urandom_range(0, 3) == 0)
                                                       : ($urandom_range(0, 1) == 1));
      end
    end
  end

  // check each accepted result against the oldest expectation
  always @(posedge clk_i) begin
    normal_word_t w;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_normals.size() == 0) begin
        $error("unexpected result word");
        errors++;
      end else begin
        w = pending_normals.pop_front();
        if (normal_x_o !== w.nx) begin
          $error("normal_x expected %0d got %0d", w.nx, normal_x_o);
          errors++;
        end
        if (normal_y_o !== w.ny) begin
          $error("normal_y expected %0d got %0d", w.ny, normal_y_o);
          errors++;
        end
        if (normal_z_o !== w.nz) begin
          $error("normal_z expected %0d got %0d", w.nz, normal_z_o);
          errors++;
        end
        if (zero_normal_o !== w.zero) begin
          $error("zero_normal expected %0d got %0d", w.zero, zero_normal_o);
          errors++;
        end
      end
    end
  end

  initial begin
    #4000000;
    $display("tb failed");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_saturation();
    test_random(160);
    drain_results();
    if (errors == 0) $display("tb passed");
    else $display("tb failed");
    $finish;
  end

endmodule

/* filelist.f */
design/mvne_pkg.sv
design/mvne_ctrl.sv
design/mvne_dp.sv
design/mesh_vertex_normal_engine_core.sv
bench/tb.sv
